// ===== hdl/clq_pkg.sv =====
// Package for the completion queue ledger: sizes, codes and word types.
// No dependencies; imported by every module of the ledger.
package clq_pkg;

	localparam int DEPTH     = 16;
	localparam int MSI_SLOTS = 16;
	localparam int SCAN_N    = (DEPTH > MSI_SLOTS) ? DEPTH : MSI_SLOTS;
	localparam int SCAN_W    = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
	localparam int SLOT_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MSI_W     = (MSI_SLOTS > 1) ? $clog2(MSI_SLOTS) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int KEY_W     = 64 + 8 + 64 + 64 + 32;

	localparam logic [3:0] KIND_RESERVE  = 4'd0;
	localparam logic [3:0] KIND_READY    = 4'd1;
	localparam logic [3:0] KIND_SELECT   = 4'd2;
	localparam logic [3:0] KIND_ASSIGN   = 4'd3;
	localparam logic [3:0] KIND_ISSUE    = 4'd4;
	localparam logic [3:0] KIND_COMPLETE = 4'd5;
	localparam logic [3:0] KIND_ACK      = 4'd6;
	localparam logic [3:0] KIND_LIST     = 4'd7;
	localparam logic [3:0] KIND_RETIRE   = 4'd8;
	localparam logic [3:0] KIND_FATAL    = 4'd9;

	localparam logic [1:0] OWN_FREE  = 2'd0;
	localparam logic [1:0] OWN_LIVE  = 2'd1;
	localparam logic [1:0] OWN_FATAL = 2'd2;

	localparam logic [1:0] MSI_EMPTY   = 2'd0;
	localparam logic [1:0] MSI_PENDING = 2'd1;
	localparam logic [1:0] MSI_OKAY    = 2'd2;
	localparam logic [1:0] MSI_ERROR   = 2'd3;

	localparam logic [1:0] RESP_OKAY = 2'd0;

	localparam logic [2:0] ST_DONE        = 3'd0;
	localparam logic [2:0] ST_REFUSED     = 3'd1;
	localparam logic [2:0] ST_STALE       = 3'd2;
	localparam logic [2:0] ST_DUP         = 3'd3;
	localparam logic [2:0] ST_FUTURE      = 3'd4;
	localparam logic [2:0] ST_AFTER_FATAL = 3'd5;
	localparam logic [2:0] ST_NONE        = 3'd6;

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] obligation_id;
		logic [63:0] sq_sequence;
		logic [63:0] tick;
		logic [7:0]  qos;
		logic [63:0] effective_request;
		logic [31:0] axi_id;
		logic [1:0]  axi_resp;
		logic [63:0] ack_sequence;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] result_id;
		logic [63:0] cq_sequence_out;
		logic [4:0]  live_count;
		logic [4:0]  fatal_count;
		logic        last;
	} out_t;

	// command word handed from the front queue to the engine
	typedef struct packed {
		in_t  word;
		logic known;
		logic scan;
	} cmd_t;

endpackage

// ===== hdl/clq_front.sv =====
// Front end of the ledger: two-entry input queue that classifies each word.
// Depends on clq_pkg.
module clq_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  clq_pkg::in_t  req,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output clq_pkg::cmd_t cmd
);
	import clq_pkg::*;

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cls;
	logic       push;
	logic       pop;

	always_comb begin
		cls.word  = req;
		cls.known = (req.kind <= KIND_FATAL);
		// kinds that walk the slot or MSI tables
		cls.scan  = (req.kind == KIND_RESERVE) || (req.kind == KIND_READY) ||
			(req.kind == KIND_SELECT) || (req.kind == KIND_ASSIGN) ||
			(req.kind == KIND_ISSUE) || (req.kind == KIND_COMPLETE) ||
			(req.kind == KIND_LIST) || (req.kind == KIND_RETIRE);
	end

	assign req_ready = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = req_valid && req_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== hdl/clq_engine.sv =====
// Back end of the ledger: slot and MSI tables plus the sequencer that walks
// them one entry per cycle. Depends on clq_pkg.
module clq_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  clq_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_ready,
	output clq_pkg::out_t res
);
	import clq_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_FIN  = 3'd2;
	localparam logic [2:0] S_ADV  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	// slot table
	logic [1:0]  owner_q [DEPTH];
	logic        rdy_q   [DEPTH];
	logic        cqf_q   [DEPTH];
	logic [31:0] ident_q [DEPTH];
	logic [63:0] sub_q   [DEPTH];
	logic [63:0] tick_q  [DEPTH];
	logic [7:0]  qos_q   [DEPTH];
	logic [63:0] eff_q   [DEPTH];
	logic [63:0] cqseq_q [DEPTH];
	// MSI ring
	logic [1:0]  msi_st_q [MSI_SLOTS];
	logic [31:0] msi_id_q [MSI_SLOTS];

	logic [31:0]      next_ident_q;
	logic [63:0]      next_cq_q;
	logic [63:0]      issued_q;
	logic [63:0]      notified_q;
	logic [63:0]      acked_q;
	logic             fatal_q;
	logic [MSI_W-1:0] iidx_q;
	logic [MSI_W-1:0] nidx_q;
	logic [CNT_W-1:0] live_q;
	logic [CNT_W-1:0] fat_q;

	logic [2:0]        state_q;
	in_t               cmd_q;
	logic [SCAN_W-1:0] idx_q;
	logic              found_q;
	logic [SLOT_W-1:0] fidx_q;
	logic              f_ready_q;
	logic              f_cq_q;
	logic [63:0]       f_cqseq_q;
	logic [KEY_W-1:0]  best_key_q;
	logic [31:0]       best_id_q;
	logic              mfound_q;
	logic [MSI_W-1:0]  midx_q;
	logic              dup_q;
	logic [31:0]       pend_q;
	logic              have_pend_q;
	logic              more_q;
	logic [2:0]        res_status_q;
	logic [31:0]       res_rid_q;
	logic [63:0]       res_cqo_q;
	logic              res_last_q;

	logic [SLOT_W-1:0] s_i;
	logic [MSI_W-1:0]  m_i;
	logic [MSI_W-1:0]  m_rd;
	logic              s_ok;
	logic              m_ok;
	logic              s_live;
	logic              s_idmatch;
	logic              s_free;
	logic              s_retire;
	logic              s_sel;
	logic [KEY_W-1:0]  s_key;
	logic              m_match;
	logic [63:0]       covered;
	logic              scan_end;
	logic              fin;
	logic              do_reserve;
	logic              do_ready;
	logic              do_assign;
	logic              do_issue;
	logic              do_complete;
	logic              do_retire;
	logic              do_fatal;
	logic              do_adv;
	logic              adv_more;

	assign s_i  = idx_q[SLOT_W-1:0];
	assign m_i  = idx_q[MSI_W-1:0];
	assign s_ok = ((SCAN_W + 1)'(idx_q) < (SCAN_W + 1)'(DEPTH));
	assign m_ok = ((SCAN_W + 1)'(idx_q) < (SCAN_W + 1)'(MSI_SLOTS));
	assign m_rd = (state_q == S_ADV) ? nidx_q : m_i;

	assign covered   = (acked_q < notified_q) ? acked_q : notified_q;
	assign s_live    = s_ok && (owner_q[s_i] == OWN_LIVE);
	assign s_idmatch = s_live && (ident_q[s_i] == cmd_q.obligation_id);
	assign s_free    = s_ok && (owner_q[s_i] == OWN_FREE);
	assign s_retire  = s_live && cqf_q[s_i] && (cqseq_q[s_i] < covered);
	assign s_sel     = s_live && rdy_q[s_i] && !cqf_q[s_i] && (tick_q[s_i] <= cmd_q.tick);
	// lexicographic selection key; inverted qos serves higher qos first
	assign s_key     = {tick_q[s_i], ~qos_q[s_i], eff_q[s_i], sub_q[s_i], ident_q[s_i]};
	assign m_match   = m_ok && (msi_st_q[m_rd] == MSI_PENDING) &&
		(msi_id_q[m_rd] == cmd_q.axi_id);
	assign scan_end  = (idx_q == SCAN_W'(SCAN_N - 1));

	assign fin         = (state_q == S_FIN);
	assign do_reserve  = fin && (cmd_q.kind == KIND_RESERVE) && found_q;
	assign do_ready    = fin && (cmd_q.kind == KIND_READY) && found_q && !f_ready_q && !f_cq_q;
	assign do_assign   = fin && (cmd_q.kind == KIND_ASSIGN) && found_q && f_ready_q &&
		!f_cq_q && (next_cq_q != '1);
	assign do_issue    = fin && (cmd_q.kind == KIND_ISSUE) && found_q && f_cq_q &&
		(f_cqseq_q != '1) && (f_cqseq_q == issued_q) &&
		((issued_q - notified_q) < 64'(MSI_SLOTS)) && !dup_q;
	assign do_complete = fin && (cmd_q.kind == KIND_COMPLETE) && mfound_q;
	assign do_retire   = fin && (cmd_q.kind == KIND_RETIRE) && found_q && f_cq_q &&
		(f_cqseq_q < covered);
	assign do_fatal    = fin && (cmd_q.kind == KIND_FATAL);
	assign adv_more    = (notified_q < issued_q) && (msi_st_q[m_rd] == MSI_OKAY);
	assign do_adv      = (state_q == S_ADV) && adv_more;

	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_EMIT);

	always_comb begin
		res.status          = res_status_q;
		res.result_id       = res_rid_q;
		res.cq_sequence_out = res_cqo_q;
		res.live_count      = 5'(live_q);
		res.fatal_count     = 5'(fat_q);
		res.last            = res_last_q;
	end

	// slot ownership and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				owner_q[i] <= OWN_FREE;
				rdy_q[i]   <= 1'b0;
				cqf_q[i]   <= 1'b0;
			end
		end else begin
			for (int i = 0; i < DEPTH; i++) begin
				if (do_fatal && (owner_q[i] == OWN_LIVE)) begin
					owner_q[i] <= OWN_FATAL;
				end
				if (fidx_q == SLOT_W'(i)) begin
					if (do_reserve) begin
						owner_q[i] <= OWN_LIVE;
						rdy_q[i]   <= 1'b0;
						cqf_q[i]   <= 1'b0;
					end
					if (do_retire) begin
						owner_q[i] <= OWN_FREE;
						rdy_q[i]   <= 1'b0;
						cqf_q[i]   <= 1'b0;
					end
					if (do_ready) begin
						rdy_q[i] <= 1'b1;
					end
					if (do_assign) begin
						cqf_q[i] <= 1'b1;
					end
				end
			end
		end
	end

	// slot payload, written only where the flags above are set
	always_ff @(posedge clk) begin
		if (do_reserve) begin
			ident_q[fidx_q] <= next_ident_q;
			sub_q[fidx_q]   <= cmd_q.sq_sequence;
		end
		if (do_ready) begin
			tick_q[fidx_q] <= cmd_q.tick;
			qos_q[fidx_q]  <= cmd_q.qos;
			eff_q[fidx_q]  <= cmd_q.effective_request;
		end
		if (do_assign) begin
			cqseq_q[fidx_q] <= next_cq_q;
		end
		if (do_issue) begin
			msi_id_q[iidx_q] <= cmd_q.axi_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MSI_SLOTS; i++) begin
				msi_st_q[i] <= MSI_EMPTY;
			end
		end else begin
			if (do_issue) begin
				msi_st_q[iidx_q] <= MSI_PENDING;
			end
			if (do_complete) begin
				msi_st_q[midx_q] <= (cmd_q.axi_resp == RESP_OKAY) ? MSI_OKAY : MSI_ERROR;
			end
			if (do_adv) begin
				msi_st_q[nidx_q] <= MSI_EMPTY;
			end
		end
	end

	// ledger counters and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_ident_q <= 32'd1;
			next_cq_q    <= '0;
			issued_q     <= '0;
			notified_q   <= '0;
			acked_q      <= '0;
			fatal_q      <= 1'b0;
			iidx_q       <= '0;
			nidx_q       <= '0;
			live_q       <= '0;
			fat_q        <= '0;
			state_q      <= S_IDLE;
			idx_q        <= '0;
			found_q      <= 1'b0;
			mfound_q     <= 1'b0;
			dup_q        <= 1'b0;
			have_pend_q  <= 1'b0;
			more_q       <= 1'b0;
		end else begin
			if (do_reserve) begin
				next_ident_q <= next_ident_q + 32'd1;
				live_q       <= live_q + CNT_W'(1);
			end
			if (do_assign) begin
				next_cq_q <= next_cq_q + 64'd1;
			end
			if (do_issue) begin
				issued_q <= issued_q + 64'd1;
				iidx_q   <= (iidx_q == MSI_W'(MSI_SLOTS - 1)) ? '0 : iidx_q + MSI_W'(1);
			end
			if (do_adv) begin
				notified_q <= notified_q + 64'd1;
				nidx_q     <= (nidx_q == MSI_W'(MSI_SLOTS - 1)) ? '0 : nidx_q + MSI_W'(1);
			end
			if (do_retire) begin
				live_q <= live_q - CNT_W'(1);
			end
			if (do_fatal) begin
				fatal_q <= 1'b1;
				fat_q   <= fat_q + live_q;
				live_q  <= '0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q       <= cmd.word;
						idx_q       <= '0;
						found_q     <= 1'b0;
						mfound_q    <= 1'b0;
						dup_q       <= 1'b0;
						have_pend_q <= 1'b0;
						more_q      <= 1'b0;
						if (!cmd.known || !cmd.scan) begin
							state_q <= S_FIN;
						end else if ((cmd.word.kind == KIND_RESERVE) && (fatal_q ||
								(live_q == CNT_W'(DEPTH)) || (next_ident_q == '0))) begin
							state_q <= S_FIN;
						end else if ((cmd.word.kind == KIND_COMPLETE) && fatal_q) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					case (cmd_q.kind) inside
						KIND_RESERVE: begin
							if (s_free && !found_q) begin
								found_q <= 1'b1;
								fidx_q  <= s_i;
							end
						end
						KIND_READY, KIND_ASSIGN, KIND_ISSUE, KIND_RETIRE: begin
							if (s_idmatch && !found_q) begin
								found_q   <= 1'b1;
								fidx_q    <= s_i;
								f_ready_q <= rdy_q[s_i];
								f_cq_q    <= cqf_q[s_i];
								f_cqseq_q <= cqseq_q[s_i];
							end
							if (m_match) begin
								dup_q <= 1'b1;
							end
						end
						KIND_SELECT: begin
							if (s_sel && (!found_q || (s_key < best_key_q))) begin
								found_q    <= 1'b1;
								best_key_q <= s_key;
								best_id_q  <= ident_q[s_i];
							end
						end
						KIND_COMPLETE: begin
							if (m_match && !mfound_q) begin
								mfound_q <= 1'b1;
								midx_q   <= m_i;
							end
						end
						KIND_LIST: begin
							// least retirable id above the last one found
							if (s_retire && (!have_pend_q || (ident_q[s_i] > pend_q)) &&
									(!found_q || (ident_q[s_i] < best_id_q))) begin
								found_q   <= 1'b1;
								best_id_q <= ident_q[s_i];
							end
						end
						default: begin
						end
					endcase
					idx_q <= idx_q + SCAN_W'(1);
					if (scan_end) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					res_status_q <= ST_REFUSED;
					res_rid_q    <= '0;
					res_cqo_q    <= '0;
					res_last_q   <= 1'b1;
					state_q      <= S_EMIT;
					case (cmd_q.kind)
						KIND_RESERVE: begin
							if (found_q) begin
								res_status_q <= ST_DONE;
								res_rid_q    <= next_ident_q;
							end
						end
						KIND_READY: begin
							if (do_ready) begin
								res_status_q <= ST_DONE;
							end
						end
						KIND_SELECT: begin
							res_status_q <= found_q ? ST_DONE : ST_NONE;
							res_rid_q    <= found_q ? best_id_q : '0;
						end
						KIND_ASSIGN: begin
							if (do_assign) begin
								res_status_q <= ST_DONE;
								res_cqo_q    <= next_cq_q;
							end
						end
						KIND_ISSUE: begin
							if (do_issue) begin
								res_status_q <= ST_DONE;
							end
						end
						KIND_COMPLETE: begin
							if (do_complete) begin
								res_status_q <= ST_DONE;
								state_q      <= S_ADV;
							end
						end
						KIND_ACK: begin
							if (fatal_q) begin
								res_status_q <= ST_AFTER_FATAL;
							end else if (cmd_q.ack_sequence < acked_q) begin
								res_status_q <= ST_STALE;
							end else if (cmd_q.ack_sequence == acked_q) begin
								res_status_q <= ST_DUP;
							end else if (cmd_q.ack_sequence > issued_q) begin
								res_status_q <= ST_FUTURE;
							end else begin
								res_status_q <= ST_DONE;
								acked_q      <= cmd_q.ack_sequence;
							end
						end
						KIND_LIST: begin
							// one pass behind: a held id goes out once the next pass
							// tells whether it was the last
							if (have_pend_q) begin
								res_status_q <= ST_DONE;
								res_rid_q    <= pend_q;
								res_last_q   <= !found_q;
								more_q       <= found_q;
								pend_q       <= best_id_q;
							end else if (found_q) begin
								pend_q      <= best_id_q;
								have_pend_q <= 1'b1;
								idx_q       <= '0;
								found_q     <= 1'b0;
								state_q     <= S_SCAN;
							end else begin
								res_status_q <= ST_NONE;
								more_q       <= 1'b0;
							end
						end
						KIND_RETIRE: begin
							if (do_retire) begin
								res_status_q <= ST_DONE;
							end
						end
						KIND_FATAL: begin
							res_status_q <= ST_DONE;
						end
						default: begin
						end
					endcase
				end
				S_ADV: begin
					if (!adv_more) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (res_ready) begin
						if (more_q) begin
							idx_q   <= '0;
							found_q <= 1'b0;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/completion_queue_ledger.sv =====
// Top level of the completion queue ledger: front queue, engine, result register.
// Depends on clq_pkg, clq_front and clq_engine.
//
// The ledger tracks up to DEPTH completion obligations through reserve, ready,
// assign, MSI issue and completion, ack and retire, plus a one-way fatal cut.
// Each request word yields one response word, except list_retirable, which
// yields one word per retirable entry in ascending id order (last set on the
// final one). Requests are queued two deep in front of the engine, and a
// finished response sits in its own output register, so the request side keeps
// moving while a response waits, until the queue fills. Words are handled one
// at a time by an engine that walks its tables one entry per cycle: ack, fatal
// and unknown kinds skip the walk, as do a reserve refused outright (fatal cut,
// table full or ids exhausted) and a complete after the fatal cut; reserve,
// ready, select, assign, issue, complete and retire otherwise walk all
// max(DEPTH, MSI_SLOTS) entries; complete then checks the notified prefix and
// moves it past each in-order OKAY MSI record; list_retirable walks once per
// retirable entry and once more to find that none is left, or once when there
// are none. Each word passes through the output register before it shows at
// the response port. No clearing pass is needed after reset.
module completion_queue_ledger (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  clq_pkg::in_t  req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output clq_pkg::out_t rsp
);
	import clq_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;
	out_t res;
	logic res_valid;
	logic res_ready;
	logic rsp_valid_q;
	out_t rsp_q;

	clq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	clq_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register: refills in the cycle the held word is taken
	assign res_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

endmodule

// ===== hdl/clq_checker.sv =====
// Port-level checks for the completion queue ledger, bound to the top level.
// Depends on clq_pkg and completion_queue_ledger.
module clq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input clq_pkg::in_t  req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input clq_pkg::out_t rsp
);
	import clq_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= ST_NONE)
		else $error("status code out of range");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (6'(rsp.live_count) + 6'(rsp.fatal_count)) <= 6'(DEPTH))
		else $error("live plus fatal exceeds slot count");

	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_NONE) |-> rsp.last && (rsp.result_id == '0))
		else $error("none-found word not final or carries an id");

	a_cq_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.cq_sequence_out != '0) |-> (rsp.status == ST_DONE))
		else $error("cq sequence on a word that did not complete");

endmodule

bind completion_queue_ledger clq_checker u_clq_checker (.*);

// ===== tb/completion_queue_ledger_test.sv =====
// Testbench for completion_queue_ledger: directed and random request words,
// checked against an in-bench ledger predictor. Depends on clq_pkg and the RTL.
`timescale 1ns / 1ps

module completion_queue_ledger_test;
	import clq_pkg::*;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	in_t  req;
	logic rsp_valid;
	logic rsp_ready;
	out_t rsp;

	completion_queue_ledger u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// ---------------- predictor state ----------------
	logic [1:0]  own [DEPTH];
	logic [31:0] ident [DEPTH];
	logic [63:0] sub_seq [DEPTH];
	logic        rdy_f [DEPTH];
	logic [63:0] rdy_tick [DEPTH];
	logic [7:0]  prio [DEPTH];
	logic [63:0] eff_req [DEPTH];
	logic        cq_f [DEPTH];
	logic [63:0] cq_seq [DEPTH];
	logic [1:0]  msi_st [MSI_SLOTS];
	logic [31:0] msi_id [MSI_SLOTS];
	logic [31:0] id_next;
	logic [63:0] cq_next;
	logic [63:0] issued;
	logic [63:0] notified;
	logic [63:0] acked;
	logic        cut;

	out_t expected_words[$];
	int   errors;
	bit   hold_rsp;      // long receiver hold-off request
	int   idle_pct;      // sender/receiver idle percentage

	function automatic int find_live(logic [31:0] id);
		for (int i = 0; i < DEPTH; i++)
			if (own[i] == OWN_LIVE && ident[i] == id)
				return i;
		return -1;
	endfunction

	function automatic int count_own(logic [1:0] who);
		int n;
		n = 0;
		for (int i = 0; i < DEPTH; i++)
			if (own[i] == who)
				n++;
		return n;
	endfunction

	function automatic bit retirable(int i);
		logic [63:0] covered;
		covered = (acked < notified) ? acked : notified;
		return own[i] == OWN_LIVE && cq_f[i] && cq_seq[i] < covered;
	endfunction

	// ordering of selection: tick, inverted qos, effective request, sq seq, id
	function automatic bit orders_first(int a, int b);
		logic [7:0] qa, qb;
		qa = 8'd255 - prio[a];
		qb = 8'd255 - prio[b];
		if (rdy_tick[a] != rdy_tick[b]) return rdy_tick[a] < rdy_tick[b];
		if (qa != qb) return qa < qb;
		if (eff_req[a] != eff_req[b]) return eff_req[a] < eff_req[b];
		if (sub_seq[a] != sub_seq[b]) return sub_seq[a] < sub_seq[b];
		return ident[a] < ident[b];
	endfunction

	task automatic ledger_reset();
		for (int i = 0; i < DEPTH; i++) begin
			own[i] = OWN_FREE; rdy_f[i] = 0; cq_f[i] = 0;
			ident[i] = 0; sub_seq[i] = 0; rdy_tick[i] = 0; prio[i] = 0;
			eff_req[i] = 0; cq_seq[i] = 0;
		end
		for (int i = 0; i < MSI_SLOTS; i++) begin
			msi_st[i] = MSI_EMPTY; msi_id[i] = 0;
		end
		id_next = 1; cq_next = 0; issued = 0; notified = 0; acked = 0; cut = 0;
	endtask

	// apply one request word to the ledger copy and queue the response words
	task automatic ledger_step(in_t w);
		logic [2:0]  st [DEPTH+1];
		logic [31:0] rid [DEPTH+1];
		logic [63:0] cqo;
		int n, s, i, e;
		bit dup, have_prev;
		logic [31:0] prev;
		out_t o;
		n = 1; st[0] = ST_REFUSED; rid[0] = 0; cqo = 0;
		case (w.kind)
			KIND_RESERVE: begin
				if (!cut && count_own(OWN_LIVE) < DEPTH && id_next != 0) begin
					for (i = 0; i < DEPTH; i++)
						if (own[i] == OWN_FREE)
							break;
					if (i < DEPTH) begin
						own[i] = OWN_LIVE; ident[i] = id_next; sub_seq[i] = w.sq_sequence;
						rdy_f[i] = 0; cq_f[i] = 0;
						rid[0] = id_next; id_next++; st[0] = ST_DONE;
					end
				end
			end
			KIND_READY: begin
				s = find_live(w.obligation_id);
				if (s >= 0 && !rdy_f[s] && !cq_f[s]) begin
					rdy_f[s] = 1; rdy_tick[s] = w.tick; prio[s] = w.qos;
					eff_req[s] = w.effective_request; st[0] = ST_DONE;
				end
			end
			KIND_SELECT: begin
				s = -1;
				for (i = 0; i < DEPTH; i++) begin
					if (own[i] != OWN_LIVE || !rdy_f[i] || cq_f[i] || rdy_tick[i] > w.tick)
						continue;
					if (s < 0 || orders_first(i, s))
						s = i;
				end
				if (s >= 0) begin
					st[0] = ST_DONE; rid[0] = ident[s];
				end else
					st[0] = ST_NONE;
			end
			KIND_ASSIGN: begin
				s = find_live(w.obligation_id);
				if (s >= 0 && rdy_f[s] && !cq_f[s] && cq_next != '1) begin
					cq_f[s] = 1; cq_seq[s] = cq_next; cqo = cq_next; cq_next++;
					st[0] = ST_DONE;
				end
			end
			KIND_ISSUE: begin
				s = find_live(w.obligation_id);
				if (s >= 0 && cq_f[s] && cq_seq[s] != '1 && cq_seq[s] == issued &&
						issued - notified < 64'(MSI_SLOTS)) begin
					dup = 0;
					for (i = 0; i < MSI_SLOTS; i++)
						if (msi_st[i] == MSI_PENDING && msi_id[i] == w.axi_id)
							dup = 1;
					if (!dup) begin
						e = int'(issued % 64'(MSI_SLOTS));
						msi_st[e] = MSI_PENDING; msi_id[e] = w.axi_id; issued++;
						st[0] = ST_DONE;
					end
				end
			end
			KIND_COMPLETE: begin
				if (!cut) begin
					for (i = 0; i < MSI_SLOTS; i++) begin
						if (msi_st[i] == MSI_PENDING && msi_id[i] == w.axi_id) begin
							msi_st[i] = (w.axi_resp == RESP_OKAY) ? MSI_OKAY : MSI_ERROR;
							// walk the notified prefix over in-order OKAY records
							while (notified < issued) begin
								e = int'(notified % 64'(MSI_SLOTS));
								if (msi_st[e] != MSI_OKAY)
									break;
								msi_st[e] = MSI_EMPTY;
								notified++;
							end
							st[0] = ST_DONE;
							break;
						end
					end
				end
			end
			KIND_ACK: begin
				if (cut) st[0] = ST_AFTER_FATAL;
				else if (w.ack_sequence < acked) st[0] = ST_STALE;
				else if (w.ack_sequence == acked) st[0] = ST_DUP;
				else if (w.ack_sequence > issued) st[0] = ST_FUTURE;
				else begin
					acked = w.ack_sequence; st[0] = ST_DONE;
				end
			end
			KIND_LIST: begin
				have_prev = 0; prev = 0; n = 0;
				for (int k = 0; k < DEPTH; k++) begin
					s = -1;
					for (i = 0; i < DEPTH; i++) begin
						if (!retirable(i) || (have_prev && ident[i] <= prev))
							continue;
						if (s < 0 || ident[i] < ident[s])
							s = i;
					end
					if (s < 0)
						break;
					st[n] = ST_DONE; rid[n] = ident[s]; n++;
					prev = ident[s]; have_prev = 1;
				end
				if (n == 0) begin
					st[0] = ST_NONE; rid[0] = 0; n = 1;
				end
			end
			KIND_RETIRE: begin
				s = find_live(w.obligation_id);
				if (s >= 0 && retirable(s)) begin
					own[s] = OWN_FREE; rdy_f[s] = 0; cq_f[s] = 0; st[0] = ST_DONE;
				end
			end
			KIND_FATAL: begin
				cut = 1;
				for (i = 0; i < DEPTH; i++)
					if (own[i] == OWN_LIVE)
						own[i] = OWN_FATAL;
				st[0] = ST_DONE;
			end
			default: ;
		endcase
		for (int k = 0; k < n; k++) begin
			o.status = st[k];
			o.result_id = rid[k];
			o.cq_sequence_out = (w.kind == KIND_ASSIGN && st[k] == ST_DONE) ? cqo : '0;
			o.live_count = 5'(count_own(OWN_LIVE));
			o.fatal_count = 5'(count_own(OWN_FATAL));
			o.last = (k == n - 1);
			expected_words = {expected_words, o};
		end
	endtask

	// ---------------- clock, reset, limit ----------------
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("completion_queue_ledger_test NOT OK");
		$finish;
	end

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
	endtask

	// ---------------- response side ----------------
	// receiver: random stall, or a long hold-off when hold_rsp is set
	initial begin
		rsp_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp)
				rsp_ready <= 0;
			else
				rsp_ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// checker: compare each accepted word with the oldest expectation
	initial begin
		out_t want;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready) begin
				if (expected_words.size() == 0) begin
					report("unexpected word", 64'(rsp.result_id), 64'd0);
				end else begin
					want = expected_words.pop_front();
					if (rsp.status !== want.status)
						report("status", 64'(rsp.status), 64'(want.status));
					if (rsp.result_id !== want.result_id)
						report("result_id", 64'(rsp.result_id), 64'(want.result_id));
					if (rsp.cq_sequence_out !== want.cq_sequence_out)
						report("cq_sequence_out", rsp.cq_sequence_out, want.cq_sequence_out);
					if (rsp.live_count !== want.live_count)
						report("live_count", 64'(rsp.live_count), 64'(want.live_count));
					if (rsp.fatal_count !== want.fatal_count)
						report("fatal_count", 64'(rsp.fatal_count), 64'(want.fatal_count));
					if (rsp.last !== want.last)
						report("last", 64'(rsp.last), 64'(want.last));
				end
			end
		end
	end

	// ---------------- request side ----------------
	// send one word: optional random idle first, then hold valid until accepted;
	// valid stays up after the accepting edge for the next word or idle_req
	task automatic send_word(in_t w);
		if ($urandom_range(99) < idle_pct) begin
			req_valid <= 0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		req <= w;
		req_valid <= 1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		ledger_step(w);
	endtask

	task automatic idle_req();
		req_valid <= 0;
	endtask

	task automatic drain();
		idle_req();
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic in_t rand_word(logic [3:0] kind);
		in_t w;
		w.kind = kind;
		w.obligation_id = $urandom();
		w.sq_sequence = {$urandom(), $urandom()};
		w.tick = {$urandom(), $urandom()};
		w.qos = 8'($urandom());
		w.effective_request = {$urandom(), $urandom()};
		w.axi_id = $urandom();
		w.axi_resp = 2'($urandom());
		w.ack_sequence = {$urandom(), $urandom()};
		return w;
	endfunction

	// id of a random known obligation (live or recently used), small ids
	function automatic logic [31:0] pick_id();
		int s;
		s = $urandom_range(DEPTH - 1);
		if (own[s] != OWN_FREE && $urandom_range(9) < 8)
			return ident[s];
		return (id_next > 3) ? $urandom_range(id_next + 1) : $urandom_range(4);
	endfunction

	// well-formed word for the current ledger state, with random content
	function automatic in_t shaped_word();
		in_t w;
		int r;
		r = $urandom_range(99);
		w = rand_word(KIND_RESERVE);
		w.obligation_id = pick_id();
		w.tick = 64'($urandom_range(40));
		w.qos = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(3) * 85);
		w.effective_request = 64'($urandom_range(5));
		w.sq_sequence = 64'($urandom_range(5));
		w.axi_id = $urandom_range(20);
		w.axi_resp = ($urandom_range(9) == 0) ? 2'($urandom_range(1, 3)) : RESP_OKAY;
		w.ack_sequence = 64'($urandom_range(32'(issued) + 32'd1));
		if (r < 16) w.kind = KIND_RESERVE;
		else if (r < 30) w.kind = KIND_READY;
		else if (r < 38) w.kind = KIND_SELECT;
		else if (r < 50) w.kind = KIND_ASSIGN;
		else if (r < 62) w.kind = KIND_ISSUE;
		else if (r < 74) w.kind = KIND_COMPLETE;
		else if (r < 82) w.kind = KIND_ACK;
		else if (r < 87) w.kind = KIND_LIST;
		else if (r < 96) w.kind = KIND_RETIRE;
		else w.kind = 4'($urandom_range(10, 15));   // unknown kinds
		// issue: aim at the entry whose sequence is next to be issued
		if (w.kind == KIND_ISSUE)
			for (int i = 0; i < DEPTH; i++)
				if (own[i] == OWN_LIVE && cq_f[i] && cq_seq[i] == issued && $urandom_range(3) != 0)
					w.obligation_id = ident[i];
		// complete: aim at a pending record
		if (w.kind == KIND_COMPLETE)
			for (int i = 0; i < MSI_SLOTS; i++)
				if (msi_st[i] == MSI_PENDING && $urandom_range(2) == 0)
					w.axi_id = msi_id[i];
		return w;
	endfunction

	// ---------------- tests ----------------
	task automatic test_directed();
		in_t w;
		w = '0;
		w.kind = KIND_SELECT; w.tick = '1; send_word(w);        // nothing to select
		w = '0; w.kind = KIND_LIST; send_word(w);                // empty retirable list
		w = '0; w.kind = KIND_READY; w.obligation_id = '1; send_word(w); // unknown id
		for (int i = 0; i < 3; i++) begin
			w = '0; w.kind = KIND_RESERVE; w.sq_sequence = (i == 0) ? '1 : 64'(i);
			send_word(w);
		end
		w = '0; w.kind = KIND_READY; w.obligation_id = 1; w.tick = 5; w.qos = 8'hff;
		w.effective_request = '1; send_word(w);
		send_word(w);                                            // ready twice
		w.obligation_id = 2; w.tick = 5; w.qos = 0; w.effective_request = 0; send_word(w);
		w.obligation_id = 3; w.tick = '1; w.qos = 8'h80; send_word(w);
		w = '0; w.kind = KIND_SELECT; w.tick = 4; send_word(w);   // before any tick
		w.tick = '1; send_word(w);
		w = '0; w.kind = KIND_ASSIGN; w.obligation_id = 1; send_word(w);
		w = '0; w.kind = KIND_READY; w.obligation_id = 1; send_word(w); // after assign
		w = '0; w.kind = KIND_ISSUE; w.obligation_id = 1; w.axi_id = '1; send_word(w);
		w = '0; w.kind = KIND_ACK; w.ack_sequence = 0; send_word(w);    // duplicate
		w.ack_sequence = '1; send_word(w);                              // future
		w = '0; w.kind = KIND_COMPLETE; w.axi_id = '1; w.axi_resp = RESP_OKAY; send_word(w);
		w = '0; w.kind = KIND_ACK; w.ack_sequence = 1; send_word(w);
		w = '0; w.kind = KIND_LIST; send_word(w);
		w = '0; w.kind = KIND_RETIRE; w.obligation_id = 1; send_word(w);
		send_word(w);                                                    // retire twice
		w = '0; w.kind = 4'hf; send_word(w);                             // unknown kind
		drain();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_word(($urandom_range(9) == 0) ? rand_word(4'($urandom())) : shaped_word());
		drain();
	endtask

	// receiver holds off while the sender keeps offering; block must back up
	task automatic test_backpressure();
		in_t w;
		hold_rsp = 1;
		fork
			begin
				for (int c = 0; c < 400; c++)
					@(posedge clk);
				hold_rsp = 0;
			end
			begin
				for (int i = 0; i < 8; i++) begin
					w = rand_word(KIND_ACK);
					send_word(w);
				end
			end
		join
		drain();
	endtask

	task automatic test_fatal();
		in_t w;
		w = '0; w.kind = KIND_FATAL; send_word(w);
		send_word(w);                                    // fatal again
		w = '0; w.kind = KIND_RESERVE; send_word(w);
		w = '0; w.kind = KIND_ACK; w.ack_sequence = 1; send_word(w);
		w = '0; w.kind = KIND_COMPLETE; send_word(w);
		test_random(25);
	endtask

	initial begin
		errors = 0;
		hold_rsp = 0;
		idle_pct = 21;
		ledger_reset();
		arst_n = 0;
		req_valid = 0;
		req = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(120);
		idle_pct = 0;                  // stretch with no idling on either side
		test_random(60);
		idle_pct = 21;
		test_backpressure();
		test_random(100);
		test_fatal();
		drain();
		if (errors == 0)
			$display("completion_queue_ledger_test OK");
		else
			$display("completion_queue_ledger_test NOT OK");
		$finish;
	end
endmodule
